### hdl/sdf_pkg.sv
package sdf_pkg;

    // fixed widths of the conversion
    localparam int MAG_W      = 64;
    localparam int BCD_DIGITS = 20;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int CNT_W      = 6;
    localparam int POS_W      = 6;

    // size codes
    localparam logic [1:0] SIZE_INT   = 2'd0;
    localparam logic [1:0] SIZE_LONG  = 2'd1;
    localparam logic [1:0] SIZE_LLONG = 2'd2;

    // sign codes
    localparam logic [1:0] SIGN_NONE  = 2'd0;
    localparam logic [1:0] SIGN_PLUS  = 2'd1;
    localparam logic [1:0] SIGN_SPACE = 2'd2;

    // ascii characters
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef struct packed {
        logic signed [63:0] value;
        logic [1:0]         value_size;
        logic [5:0]         precision;
        logic [1:0]         sign_mode;
    } num_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last;
    } txt_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic dabble;
        logic emit_sign;
        logic step_digit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic conv_done;
        logic has_sign;
        logic digit_emit;
        logic pos_zero;
        logic slot_free;
    } sts_t;

endpackage

### hdl/signed_decimal_formatter.sv
// sequence: accept, the 64-step shift-add-3 conversion, then the sign if any, then a digit walk
//   from the top position down over max(precision, 20) positions, precision capped at
//   MAX_PRECISION; the last character is registered at position zero, and no new number is
//   taken until the walk ends
// characters stall on txt_ready; one finished character waits in the output register
// reset: rst_n asynchronous, clears the controller state and the output valid
module signed_decimal_formatter #(
    parameter int MAX_PRECISION = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          num_valid,
    output logic          num_ready,
    input  sdf_pkg::num_t num,
    output logic          txt_valid,
    input  logic          txt_ready,
    output sdf_pkg::txt_t txt
);
    import sdf_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // sequencer
    sdf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .num_valid (num_valid),
        .num_ready (num_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // conversion and output datapath
    sdf_datapath #(
        .MAX_PRECISION (MAX_PRECISION)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .num       (num),
        .cmd       (cmd),
        .sts       (sts),
        .txt_valid (txt_valid),
        .txt_ready (txt_ready),
        .txt       (txt)
    );

endmodule

### hdl/sdf_ctrl.sv
module sdf_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          num_valid,
    output logic          num_ready,
    input  sdf_pkg::sts_t sts,
    output sdf_pkg::cmd_t cmd
);
    import sdf_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CONV  = 4'b0010,
        ST_SIGN  = 4'b0100,
        ST_DIGIT = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        num_ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                num_ready = 1'b1;
                if (num_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.dabble = 1'b1;
                if (sts.conv_done)
                begin
                    state_next = sts.has_sign ? ST_SIGN : ST_DIGIT;
                end
            end
            ST_SIGN:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit_sign = 1'b1;
                    state_next    = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (sts.slot_free || !sts.digit_emit)
                begin
                    cmd.step_digit = 1'b1;
                    if (sts.pos_zero)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### hdl/sdf_datapath.sv
module sdf_datapath #(
    parameter int MAX_PRECISION = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  sdf_pkg::num_t num,
    input  sdf_pkg::cmd_t cmd,
    output sdf_pkg::sts_t sts,
    output logic          txt_valid,
    input  logic          txt_ready,
    output sdf_pkg::txt_t txt
);
    import sdf_pkg::*;

    localparam logic [POS_W-1:0] MAX_P   = POS_W'(MAX_PRECISION);
    localparam logic [POS_W-1:0] NDIG    = POS_W'(BCD_DIGITS);
    localparam logic [CNT_W-1:0] LAST_CT = CNT_W'(MAG_W - 1);

    logic [MAG_W-1:0] mag_reg, mag_next;
    logic [BCD_W-1:0] bcd_reg, bcd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] prec_reg, prec_next;
    logic             seen_reg, seen_next;
    logic             has_sign_reg, has_sign_next;
    logic [7:0]       sign_ch_reg, sign_ch_next;
    logic             txt_valid_reg, txt_valid_next;
    txt_t             txt_reg, txt_next;

    logic [MAG_W-1:0] ext;
    logic             neg;
    logic [POS_W-1:0] prec_sat;
    logic [BCD_W-1:0] bcd_adj;
    logic [3:0]       cur_digit;
    logic             in_bcd;
    logic             emit_now;
    logic             slot_free;

    // operand widening and magnitude
    always_comb
    begin
        if (num.value_size == SIZE_LONG || num.value_size == SIZE_LLONG)
        begin
            ext = num.value;
        end
        else
        begin
            ext = {{(MAG_W - 32){num.value[31]}}, num.value[31:0]};
        end
        neg      = ext[MAG_W-1];
        prec_sat = (num.precision > MAX_P) ? MAX_P : num.precision;
    end

    // add-3 correction on each bcd digit
    always_comb
    begin
        for (int d = 0; d < BCD_DIGITS; d++)
        begin
            if (bcd_reg[4*d +: 4] >= 4'd5)
            begin
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4];
            end
        end
    end

    // digit at the current position, leading zeros skipped
    assign in_bcd    = pos_reg < NDIG;
    assign cur_digit = in_bcd ? bcd_reg[BCD_W-1 -: 4] : 4'd0;
    assign emit_now  = (pos_reg < prec_reg) || seen_reg || (cur_digit != 4'd0)
                       || (pos_reg == '0);
    assign slot_free = !txt_valid_reg || txt_ready;

    // next values
    always_comb
    begin
        mag_next       = mag_reg;
        bcd_next       = bcd_reg;
        cnt_next       = cnt_reg;
        pos_next       = pos_reg;
        prec_next      = prec_reg;
        seen_next      = seen_reg;
        has_sign_next  = has_sign_reg;
        sign_ch_next   = sign_ch_reg;
        txt_next       = txt_reg;
        txt_valid_next = txt_valid_reg;

        if (txt_ready)
        begin
            txt_valid_next = 1'b0;
        end

        if (cmd.load)
        begin
            mag_next  = neg ? (MAG_W'(0) - ext) : ext;
            bcd_next  = '0;
            cnt_next  = '0;
            prec_next = prec_sat;
            seen_next = 1'b0;
            pos_next  = (prec_sat > NDIG) ? (prec_sat - POS_W'(1)) : (NDIG - POS_W'(1));
            if (neg)
            begin
                has_sign_next = 1'b1;
                sign_ch_next  = CH_MINUS;
            end
            else
            begin
                case (num.sign_mode)
                    SIGN_PLUS:
                    begin
                        has_sign_next = 1'b1;
                        sign_ch_next  = CH_PLUS;
                    end
                    SIGN_SPACE:
                    begin
                        has_sign_next = 1'b1;
                        sign_ch_next  = CH_SPACE;
                    end
                    default:
                    begin
                        has_sign_next = 1'b0;
                        sign_ch_next  = CH_SPACE;
                    end
                endcase
            end
        end

        if (cmd.dabble)
        begin
            bcd_next = {bcd_adj[BCD_W-2:0], mag_reg[MAG_W-1]};
            mag_next = {mag_reg[MAG_W-2:0], 1'b0};
            cnt_next = cnt_reg + CNT_W'(1);
        end

        if (cmd.emit_sign)
        begin
            txt_next.out_char = sign_ch_reg;
            txt_next.last     = 1'b0;
            txt_valid_next    = 1'b1;
        end

        if (cmd.step_digit)
        begin
            if (emit_now)
            begin
                txt_next.out_char = CH_ZERO + {4'd0, cur_digit};
                txt_next.last     = (pos_reg == '0);
                txt_valid_next    = 1'b1;
                seen_next         = 1'b1;
            end
            if (in_bcd)
            begin
                bcd_next = {bcd_reg[BCD_W-5:0], 4'd0};
            end
            pos_next = pos_reg - POS_W'(1);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            txt_valid_reg <= 1'b0;
        end
        else
        begin
            txt_valid_reg <= txt_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        bcd_reg      <= bcd_next;
        cnt_reg      <= cnt_next;
        pos_reg      <= pos_next;
        prec_reg     <= prec_next;
        seen_reg     <= seen_next;
        has_sign_reg <= has_sign_next;
        sign_ch_reg  <= sign_ch_next;
        txt_reg      <= txt_next;
    end

    // status to controller
    assign sts.conv_done  = (cnt_reg == LAST_CT);
    assign sts.has_sign   = has_sign_reg;
    assign sts.digit_emit = emit_now;
    assign sts.pos_zero   = (pos_reg == '0);
    assign sts.slot_free  = slot_free;

    assign txt_valid = txt_valid_reg;
    assign txt       = txt_reg;

endmodule
